// ----- hdl/tnbc_pkg.sv -----
// Shared types, widths and codes of the top-N record sorter.
package tnbc_pkg;

   localparam int STORE_DEPTH  = 64;
   localparam int RESULT_LIMIT = 64;
   localparam int CNT_W        = $clog2(STORE_DEPTH + 1);
   localparam int RANK_W       = 7;
   localparam int CMP_W        = (CNT_W > RANK_W) ? CNT_W : RANK_W;

   localparam int KEY_W        = 24;
   localparam int ID_W         = 16;
   localparam int VAL_W        = 14;
   localparam int ENERGY_W     = 17;
   localparam int CAT_W        = 4;
   localparam int CRIT_W       = 3;
   localparam int TOP_W        = 7;

   localparam int REQ_DATA_W   = 80;
   localparam int RSP_DATA_W   = 48;
   localparam int CSR_ADDR_W   = 2;
   localparam int CSR_DATA_W   = 7;

   localparam int DIV_STEPS    = KEY_W;
   localparam int STEP_W       = $clog2(DIV_STEPS + 1);
   localparam int RATIO_SCALE  = 100;

   localparam logic [CAT_W-1:0] CAT_OTHER = CAT_W'(10);

   localparam logic [CRIT_W-1:0] CRIT_MOISTURE = 3'd0;
   localparam logic [CRIT_W-1:0] CRIT_ENERGY   = 3'd1;
   localparam logic [CRIT_W-1:0] CRIT_PROTEIN  = 3'd2;
   localparam logic [CRIT_W-1:0] CRIT_CARB     = 3'd3;
   localparam logic [CRIT_W-1:0] CRIT_EN_PROT  = 3'd4;
   localparam logic [CRIT_W-1:0] CRIT_EN_CARB  = 3'd5;

   localparam logic [CSR_ADDR_W-1:0] CSR_CATEGORY  = 2'd0;
   localparam logic [CSR_ADDR_W-1:0] CSR_CRITERION = 2'd1;
   localparam logic [CSR_ADDR_W-1:0] CSR_TOP_COUNT = 2'd2;

   localparam logic [CAT_W-1:0]  CATEGORY_RESET  = '0;
   localparam logic [CRIT_W-1:0] CRITERION_RESET = CRIT_ENERGY;
   localparam logic [TOP_W-1:0]  TOP_COUNT_RESET = TOP_W'(64);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DIVIDE,
      ST_INSERT,
      ST_EMIT,
      ST_NONE
   } state_type;

   typedef struct packed {
      logic             insert;
      logic             shift_up;
      logic [KEY_W-1:0] key;
      logic [ID_W-1:0]  id;
   } cell_ctl_type;

endpackage

// ----- hdl/tnbc_div.sv -----
// Restoring divider that forms one quotient bit per cycle for the ratio keys.
module tnbc_div
   import tnbc_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [KEY_W-1:0] dividend,
   input  logic [VAL_W-1:0] divisor,
   output logic             done,
   output logic [KEY_W-1:0] quotient
);

   logic [STEP_W-1:0] steps_ff, steps_in;
   logic [KEY_W-1:0]  q_ff, q_in;
   logic [VAL_W-1:0]  rem_ff, rem_in;
   logic [VAL_W-1:0]  den_ff, den_in;
   logic [VAL_W:0]    trial;
   logic [VAL_W:0]    diff;
   logic              ge;

   assign trial    = {rem_ff, q_ff[KEY_W-1]};
   assign ge       = trial >= {1'b0, den_ff};
   assign diff     = trial - {1'b0, den_ff};
   assign done     = steps_ff == STEP_W'(1);
   assign quotient = q_ff;

   always_comb begin
      steps_in = steps_ff;
      q_in     = q_ff;
      rem_in   = rem_ff;
      den_in   = den_ff;
      if (start) begin
         steps_in = STEP_W'(DIV_STEPS);
         q_in     = dividend;
         rem_in   = '0;
         den_in   = divisor;
      end else if (steps_ff != '0) begin
         steps_in = steps_ff - STEP_W'(1);
         q_in     = {q_ff[KEY_W-2:0], ge};
         rem_in   = ge ? diff[VAL_W-1:0] : trial[VAL_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         steps_ff <= '0;
      end else begin
         steps_ff <= steps_in;
      end
   end

   always_ff @(posedge clock) begin
      q_ff   <= q_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
   end

endmodule

// ----- hdl/tnbc_cell.sv -----
// One cell of the sorted chain: holds an entry, inserts in place or shifts toward the head.
module tnbc_cell
   import tnbc_pkg::*;
(
   input  logic             clock,
   input  cell_ctl_type     ctl,
   input  logic             occ_here,
   input  logic             occ_prev,
   input  logic             lt_prev,
   input  logic [KEY_W-1:0] prev_key,
   input  logic [ID_W-1:0]  prev_id,
   input  logic [KEY_W-1:0] next_key,
   input  logic [ID_W-1:0]  next_id,
   output logic [KEY_W-1:0] key,
   output logic [ID_W-1:0]  id,
   output logic             lt
);

   logic [KEY_W-1:0] key_ff, key_in;
   logic [ID_W-1:0]  id_ff, id_in;

   assign lt  = occ_here && (key_ff < ctl.key);
   assign key = key_ff;
   assign id  = id_ff;

   always_comb begin
      key_in = key_ff;
      id_in  = id_ff;
      if (ctl.shift_up) begin
         key_in = next_key;
         id_in  = next_id;
      end else if (ctl.insert) begin
         if (lt_prev) begin
            key_in = prev_key;
            id_in  = prev_id;
         end else if (lt || (occ_prev && !occ_here)) begin
            key_in = ctl.key;
            id_in  = ctl.id;
         end
      end
   end

   always_ff @(posedge clock) begin
      key_ff <= key_in;
      id_ff  <= id_in;
   end

endmodule

// ----- hdl/top_n_by_criterion_sorter.sv -----
// Top level of the top-N record sorter: control, key selection and the chain of cells.
//
// Records enter on the req_ stream, one beat per record. A record whose category
// matches the configured category gets a key and is inserted into a chain of
// sorted cells in descending order; equal keys keep arrival order. Once the
// chain is full, further matching records are dropped.
// After acceptance a record passes through the insert state before the next can be
// accepted, and first through the divide state when the key is a ratio with a nonzero
// divisor: the divider forms one quotient bit per cycle.
// The beat with req_tlast set closes the run. The chain then streams the best
// entries out of its head on rsp_, one beat per cycle while rsp_tready is high,
// with rank from 1 and rsp_tlast on the final beat; the store is then empty.
// The first result beat follows the closing beat through the divide state if needed,
// then the insert and emit states, into the output register.
// A run without matches gives a single beat with the none-found flag set.
// An output register holds each beat while rsp_tready is low; emission pauses
// and resumes without loss.
// The csr_ port writes the category, the criterion and the count; the user must write it
// only while the block is idle, which the block itself does not enforce.
// Reset empties the store, drops any pending beat and loads register defaults.
module top_n_by_criterion_sorter
   import tnbc_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   // record_id, moisture, energy, protein, carbohydrate, zero fill
   input  logic [REQ_DATA_W-1:0] req_tdata,
   // category
   input  logic [CAT_W-1:0]      req_tuser,
   input  logic                  req_tlast,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // rank, result_id, key_value, zero fill
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   // none_found
   output logic                  rsp_tuser,
   output logic                  rsp_tlast,
   input  logic                  csr_wen,
   input  logic [CSR_ADDR_W-1:0] csr_addr,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   state_type state_ff, state_in;

   logic [CAT_W-1:0]    category_ff;
   logic [CRIT_W-1:0]   criterion_ff;
   logic [TOP_W-1:0]    top_count_ff;

   logic [ID_W-1:0]     rec_id_ff;
   logic [VAL_W-1:0]    moist_ff, prot_ff, carb_ff;
   logic [ENERGY_W-1:0] energy_ff;
   logic                last_ff, match_ff;

   logic [CNT_W-1:0]    count_ff, count_in;
   logic [RANK_W-1:0]   n_ff, n_in;
   logic [RANK_W-1:0]   idx_ff, idx_in;

   logic                rsp_valid_ff, rsp_valid_in;
   logic [RANK_W-1:0]   rsp_rank_ff, rsp_rank_in;
   logic [ID_W-1:0]     rsp_id_ff, rsp_id_in;
   logic [KEY_W-1:0]    rsp_key_ff, rsp_key_in;
   logic                rsp_none_ff, rsp_none_in;
   logic                rsp_last_ff, rsp_last_in;

   logic                accept;
   logic                match;
   logic                ratio;
   logic [VAL_W-1:0]    req_den;
   logic                div_start, div_done;
   logic [KEY_W-1:0]    div_quot;
   logic [KEY_W-1:0]    new_key;
   logic                ins;
   logic [CNT_W-1:0]    count_after;
   logic [TOP_W-1:0]    top_eff;
   logic [RANK_W-1:0]   limit;
   logic [RANK_W-1:0]   n_calc;
   logic                can_load;
   logic [RANK_W-1:0]   rank_next;

   cell_ctl_type        ctl;
   logic [KEY_W-1:0]    cell_key [STORE_DEPTH];
   logic [ID_W-1:0]     cell_id  [STORE_DEPTH];
   logic                cell_lt  [STORE_DEPTH];
   logic                occ      [STORE_DEPTH];

   assign accept  = req_tvalid && req_tready;
   assign match   = (category_ff < CAT_OTHER) && (req_tuser == category_ff);
   assign ratio   = (criterion_ff == CRIT_EN_PROT) || (criterion_ff == CRIT_EN_CARB);
   assign req_den = (criterion_ff == CRIT_EN_PROT) ? req_tdata[60:47] : req_tdata[74:61];
   assign div_start = accept && match && ratio && (req_den != '0);

   tnbc_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (KEY_W'(req_tdata[46:30]) * KEY_W'(RATIO_SCALE)),
      .divisor  (req_den),
      .done     (div_done),
      .quotient (div_quot)
   );

   always_comb begin
      case (criterion_ff)
         CRIT_MOISTURE: new_key = KEY_W'(moist_ff);
         CRIT_ENERGY:   new_key = KEY_W'(energy_ff);
         CRIT_PROTEIN:  new_key = KEY_W'(prot_ff);
         CRIT_CARB:     new_key = KEY_W'(carb_ff);
         CRIT_EN_PROT:  new_key = (prot_ff == '0) ? '0 : div_quot;
         CRIT_EN_CARB:  new_key = (carb_ff == '0) ? '0 : div_quot;
         default:       new_key = '0;
      endcase
   end

   assign ins         = (state_ff == ST_INSERT) && match_ff && (count_ff < CNT_W'(STORE_DEPTH));
   assign count_after = count_ff + CNT_W'(ins);
   assign top_eff     = (top_count_ff == '0) ? TOP_W'(1) : top_count_ff;
   assign limit       = (top_eff > TOP_W'(RESULT_LIMIT)) ? RANK_W'(RESULT_LIMIT)
                                                         : RANK_W'(top_eff);
   assign n_calc      = (CMP_W'(count_after) < CMP_W'(limit)) ? RANK_W'(count_after) : limit;
   assign can_load    = !rsp_valid_ff || rsp_tready;
   assign rank_next   = idx_ff + RANK_W'(1);

   always_comb begin
      state_in     = state_ff;
      req_tready   = 1'b0;
      count_in     = count_ff;
      n_in         = n_ff;
      idx_in       = idx_ff;
      ctl.insert   = ins;
      ctl.shift_up = 1'b0;
      ctl.key      = new_key;
      ctl.id       = rec_id_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_rank_in  = rsp_rank_ff;
      rsp_id_in    = rsp_id_ff;
      rsp_key_in   = rsp_key_ff;
      rsp_none_in  = rsp_none_ff;
      rsp_last_in  = rsp_last_ff;
      case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            if (accept) begin
               state_in = div_start ? ST_DIVIDE : ST_INSERT;
            end
         end
         ST_DIVIDE: begin
            if (div_done) begin
               state_in = ST_INSERT;
            end
         end
         ST_INSERT: begin
            count_in = count_after;
            n_in     = n_calc;
            idx_in   = '0;
            if (!last_ff) begin
               state_in = ST_IDLE;
            end else if (count_after == '0) begin
               state_in = ST_NONE;
            end else begin
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (can_load) begin
               ctl.shift_up = 1'b1;
               rsp_valid_in = 1'b1;
               rsp_rank_in  = rank_next;
               rsp_id_in    = cell_id[0];
               rsp_key_in   = cell_key[0];
               rsp_none_in  = 1'b0;
               rsp_last_in  = rank_next == n_ff;
               idx_in       = rank_next;
               if (rank_next == n_ff) begin
                  count_in = '0;
                  state_in = ST_IDLE;
               end
            end
         end
         ST_NONE: begin
            if (can_load) begin
               rsp_valid_in = 1'b1;
               rsp_rank_in  = '0;
               rsp_id_in    = '0;
               rsp_key_in   = '0;
               rsp_none_in  = 1'b1;
               rsp_last_in  = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         idx_ff       <= '0;
         n_ff         <= '0;
         rsp_valid_ff <= 1'b0;
         category_ff  <= CATEGORY_RESET;
         criterion_ff <= CRITERION_RESET;
         top_count_ff <= TOP_COUNT_RESET;
      end else begin
         count_ff     <= count_in;
         idx_ff       <= idx_in;
         n_ff         <= n_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_wen) begin
            case (csr_addr)
               CSR_CATEGORY:  category_ff  <= csr_wdata[CAT_W-1:0];
               CSR_CRITERION: criterion_ff <= csr_wdata[CRIT_W-1:0];
               CSR_TOP_COUNT: top_count_ff <= csr_wdata[TOP_W-1:0];
               default: ;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rec_id_ff <= req_tdata[15:0];
         moist_ff  <= req_tdata[29:16];
         energy_ff <= req_tdata[46:30];
         prot_ff   <= req_tdata[60:47];
         carb_ff   <= req_tdata[74:61];
         last_ff   <= req_tlast;
         match_ff  <= match;
      end
      rsp_rank_ff <= rsp_rank_in;
      rsp_id_ff   <= rsp_id_in;
      rsp_key_ff  <= rsp_key_in;
      rsp_none_ff <= rsp_none_in;
      rsp_last_ff <= rsp_last_in;
   end

   for (genvar i = 0; i < STORE_DEPTH; i++) begin : g_cell
      assign occ[i] = count_ff > CNT_W'(i);
      if (i == 0) begin : g_head
         tnbc_cell u_cell (
            .clock    (clock),
            .ctl      (ctl),
            .occ_here (occ[i]),
            .occ_prev (1'b1),
            .lt_prev  (1'b0),
            .prev_key ('0),
            .prev_id  ('0),
            .next_key (cell_key[i+1]),
            .next_id  (cell_id[i+1]),
            .key      (cell_key[i]),
            .id       (cell_id[i]),
            .lt       (cell_lt[i])
         );
      end else if (i == STORE_DEPTH - 1) begin : g_tail
         tnbc_cell u_cell (
            .clock    (clock),
            .ctl      (ctl),
            .occ_here (occ[i]),
            .occ_prev (occ[i-1]),
            .lt_prev  (cell_lt[i-1]),
            .prev_key (cell_key[i-1]),
            .prev_id  (cell_id[i-1]),
            .next_key ('0),
            .next_id  ('0),
            .key      (cell_key[i]),
            .id       (cell_id[i]),
            .lt       (cell_lt[i])
         );
      end else begin : g_body
         tnbc_cell u_cell (
            .clock    (clock),
            .ctl      (ctl),
            .occ_here (occ[i]),
            .occ_prev (occ[i-1]),
            .lt_prev  (cell_lt[i-1]),
            .prev_key (cell_key[i-1]),
            .prev_id  (cell_id[i-1]),
            .next_key (cell_key[i+1]),
            .next_id  (cell_id[i+1]),
            .key      (cell_key[i]),
            .id       (cell_id[i]),
            .lt       (cell_lt[i])
         );
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {RSP_DATA_W'(rsp_key_ff) << (RANK_W + ID_W)}
                     | {RSP_DATA_W'(rsp_id_ff) << RANK_W}
                     | RSP_DATA_W'(rsp_rank_ff);
   assign rsp_tuser  = rsp_none_ff;
   assign rsp_tlast  = rsp_last_ff;

endmodule

// ----- hdl/tnbc_checker.sv -----
// Port-level checks of the top-N record sorter and their binding to the top level.
module tnbc_checker
   import tnbc_pkg::*;
(
   input logic                  clock,
   input logic                  reset,
   input logic                  rsp_tvalid,
   input logic                  rsp_tready,
   input logic [RSP_DATA_W-1:0] rsp_tdata,
   input logic                  rsp_tuser,
   input logic                  rsp_tlast
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid)
      else $error("Response beat dropped while stalled.");

   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> $stable(rsp_tdata) && $stable(rsp_tlast))
      else $error("Response beat changed while stalled.");

   a_none_last: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser |-> rsp_tlast && (rsp_tdata == '0))
      else $error("None-found beat is not a lone zero beat.");

   a_rank_nonzero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser |-> rsp_tdata[RANK_W-1:0] != '0)
      else $error("Ranked beat carries rank zero.");

   a_rank_after_last: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tready && rsp_tlast ##1 rsp_tvalid |->
      rsp_tuser || (rsp_tdata[RANK_W-1:0] == RANK_W'(1)))
      else $error("New run does not start at rank one.");

endmodule

bind top_n_by_criterion_sorter tnbc_checker u_checker (.*);

// ----- sim/top_n_rank_checker.sv -----
// Checker for the top-N record sorter: predicts ranked results from observed beats and compares.
`timescale 1ns / 1ps

module top_n_rank_checker
   import tnbc_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   input  logic                  req_tready,
   // record_id, moisture, energy, protein, carbohydrate, zero fill
   input  logic [REQ_DATA_W-1:0] req_tdata,
   // category
   input  logic [CAT_W-1:0]      req_tuser,
   input  logic                  req_tlast,
   input  logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // rank, result_id, key_value, zero fill
   input  logic [RSP_DATA_W-1:0] rsp_tdata,
   // none_found
   input  logic                  rsp_tuser,
   input  logic                  rsp_tlast,
   input  logic                  csr_wen,
   input  logic [CSR_ADDR_W-1:0] csr_addr,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   output int                    failures,
   output int                    outstanding
);

   localparam int ID_LO     = 0;
   localparam int MOIST_LO  = ID_LO + ID_W;
   localparam int ENERGY_LO = MOIST_LO + VAL_W;
   localparam int PROT_LO   = ENERGY_LO + ENERGY_W;
   localparam int CARB_LO   = PROT_LO + VAL_W;

   localparam int RANK_LO   = 0;
   localparam int RID_LO    = RANK_LO + RANK_W;
   localparam int KEY_LO    = RID_LO + ID_W;

   typedef struct packed {
      logic [RANK_W-1:0] rank_no;
      logic [ID_W-1:0]   record_id;
      logic [KEY_W-1:0]  key_value;
      logic              none_found;
      logic              last_result;
   } ranked_result_type;

   logic [CAT_W-1:0]  category_sel;
   logic [CRIT_W-1:0] criterion;
   logic [TOP_W-1:0]  top_count_cfg;

   logic [KEY_W-1:0]  ranked_keys [STORE_DEPTH];
   logic [ID_W-1:0]   ranked_ids  [STORE_DEPTH];
   int                kept_count;

   ranked_result_type awaited_ranks [$];

   function automatic logic [KEY_W-1:0] key_of(input logic [VAL_W-1:0]    moist_v,
                                                input logic [ENERGY_W-1:0] energy_v,
                                                input logic [VAL_W-1:0]    prot_v,
                                                input logic [VAL_W-1:0]    carb_v);
      longint unsigned scaled;
      scaled = 64'(energy_v) * 64'(RATIO_SCALE);
      case (criterion)
         CRIT_MOISTURE: return KEY_W'(moist_v);
         CRIT_ENERGY:   return KEY_W'(energy_v);
         CRIT_PROTEIN:  return KEY_W'(prot_v);
         CRIT_CARB:     return KEY_W'(carb_v);
         CRIT_EN_PROT:  return (prot_v == '0) ? '0 : KEY_W'(scaled / 64'(prot_v));
         CRIT_EN_CARB:  return (carb_v == '0) ? '0 : KEY_W'(scaled / 64'(carb_v));
         default:       return '0;
      endcase
   endfunction

   task automatic flag_error(input string what);
      $display("%0t ns: sorter check: %s", $time, what);
      failures++;
   endtask

   task automatic check_field(input string field, input int unsigned rank_v,
                              input longint unsigned got_v, input longint unsigned want_v);
      if (got_v != want_v)
         flag_error($sformatf("%s at rank %0d: got %0d, expected %0d",
                              field, rank_v, got_v, want_v));
   endtask

   always @(posedge clock) begin : watch
      ranked_result_type got;
      ranked_result_type want;
      logic [KEY_W-1:0]  key;
      int                pos;
      int                n;
      if (reset) begin
         category_sel  = CATEGORY_RESET;
         criterion     = CRITERION_RESET;
         top_count_cfg = TOP_COUNT_RESET;
         kept_count    = 0;
         awaited_ranks.delete();
      end else begin
         if (csr_wen) begin
            case (csr_addr)
               CSR_CATEGORY:  category_sel  = csr_wdata[CAT_W-1:0];
               CSR_CRITERION: criterion     = csr_wdata[CRIT_W-1:0];
               CSR_TOP_COUNT: top_count_cfg = csr_wdata[TOP_W-1:0];
               default: ;
            endcase
         end

         if (req_tvalid && req_tready) begin
            if (category_sel < CAT_OTHER && req_tuser == category_sel &&
                kept_count < STORE_DEPTH) begin
               key = key_of(req_tdata[MOIST_LO +: VAL_W], req_tdata[ENERGY_LO +: ENERGY_W],
                            req_tdata[PROT_LO +: VAL_W], req_tdata[CARB_LO +: VAL_W]);
               pos = kept_count;
               while (pos > 0 && ranked_keys[pos-1] < key) begin
                  ranked_keys[pos] = ranked_keys[pos-1];
                  ranked_ids[pos]  = ranked_ids[pos-1];
                  pos--;
               end
               ranked_keys[pos] = key;
               ranked_ids[pos]  = req_tdata[ID_LO +: ID_W];
               kept_count++;
            end

            if (req_tlast) begin
               if (kept_count == 0) begin
                  want = '{rank_no: '0, record_id: '0, key_value: '0,
                           none_found: 1'b1, last_result: 1'b1};
                  awaited_ranks.push_back(want);
               end else begin
                  n = (top_count_cfg == '0) ? 1 : int'(top_count_cfg);
                  if (n > kept_count) n = kept_count;
                  if (n > RESULT_LIMIT) n = RESULT_LIMIT;
                  for (int i = 0; i < n; i++) begin
                     want.rank_no     = RANK_W'(i + 1);
                     want.record_id   = ranked_ids[i];
                     want.key_value   = ranked_keys[i];
                     want.none_found  = 1'b0;
                     want.last_result = (i == n - 1);
                     awaited_ranks.push_back(want);
                  end
                  kept_count = 0;
               end
            end
         end

         if (rsp_tvalid && rsp_tready) begin
            got.rank_no     = rsp_tdata[RANK_LO +: RANK_W];
            got.record_id   = rsp_tdata[RID_LO +: ID_W];
            got.key_value   = rsp_tdata[KEY_LO +: KEY_W];
            got.none_found  = rsp_tuser;
            got.last_result = rsp_tlast;
            if (awaited_ranks.size() == 0) begin
               flag_error($sformatf("result beat with nothing pending: rank %0d id %0d",
                                    got.rank_no, got.record_id));
            end else begin
               want = awaited_ranks.pop_front();
               check_field("rank", want.rank_no, got.rank_no, want.rank_no);
               check_field("result_id", want.rank_no, got.record_id, want.record_id);
               check_field("key_value", want.rank_no, got.key_value, want.key_value);
               check_field("none_found", want.rank_no, got.none_found, want.none_found);
               check_field("last_result", want.rank_no, got.last_result, want.last_result);
            end
         end
      end
      outstanding <= awaited_ranks.size();
   end

endmodule

// ----- sim/top_n_by_criterion_sorter_test.sv -----
// Testbench top for the top-N record sorter: clock, reset, record stimulus and the verdict.
`timescale 1ns / 1ps

module top_n_by_criterion_sorter_test;
   import tnbc_pkg::*;

   localparam int LIMIT_CYCLES  = 200000;
   localparam int SETTLE_CYCLES = 40;
   localparam int HOLD_CYCLES   = 300;
   localparam int RANDOM_ITEMS  = 120;

   localparam logic [CRIT_W-1:0] CRIT_UNKNOWN = 3'd7;
   localparam int MOIST_MAX  = 10000;
   localparam int ENERGY_MAX = 100000;

   logic                  clock;
   logic                  reset      = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata  = '0;
   logic [CAT_W-1:0]      req_tuser  = '0;
   logic                  req_tlast  = 1'b0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  rsp_tuser;
   logic                  rsp_tlast;
   logic                  csr_wen    = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_addr   = '0;
   logic [CSR_DATA_W-1:0] csr_wdata  = '0;

   int errors;
   int pending;
   int cycle_count = 0;
   int burst_left  = 0;
   bit hold_armed  = 1'b0;

   top_n_by_criterion_sorter u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .csr_wen    (csr_wen),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   top_n_rank_checker u_checker (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .req_tlast   (req_tlast),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .rsp_tlast   (rsp_tlast),
      .csr_wen     (csr_wen),
      .csr_addr    (csr_addr),
      .csr_wdata   (csr_wdata),
      .failures    (errors),
      .outstanding (pending)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == LIMIT_CYCLES) begin
         $display("** top_n_by_criterion_sorter: FAILED **");
         $finish;
      end
   end

   // The receiver picks a new stall pattern for each stretch of random length; once armed, it holds
   // off for a long stretch as soon as a result beat shows up.
   initial begin : receiver
      int mode;
      int len;
      int hold_left;
      bit ready;
      hold_left = 0;
      forever begin
         mode = $urandom_range(0, 3);
         len  = $urandom_range(10, 60);
         repeat (len) begin
            if (hold_armed && rsp_tvalid) begin
               hold_armed = 1'b0;
               hold_left  = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
               hold_left--;
               ready = 1'b0;
            end else begin
               case (mode)
                  0:       ready = 1'b1;
                  1:       ready = 1'($urandom_range(0, 1));
                  2:       ready = ($urandom_range(0, 7) == 0);
                  default: ready = ($urandom_range(0, 3) != 0);
               endcase
            end
            rsp_tready <= ready;
            @(posedge clock);
         end
      end
   end

   task automatic pace_sender();
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         req_tvalid <= 1'b0;
         repeat (($urandom_range(0, 3) == 0) ? $urandom_range(13, 30) : $urandom_range(1, 12))
            @(posedge clock);
         burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 40) : $urandom_range(0, 6);
      end
   endtask

   task automatic send_record(input logic [ID_W-1:0]     id,
                              input logic [CAT_W-1:0]    cat,
                              input logic [VAL_W-1:0]    moist,
                              input logic [ENERGY_W-1:0] energy,
                              input logic [VAL_W-1:0]    prot,
                              input logic [VAL_W-1:0]    carb,
                              input logic                last);
      req_tvalid <= 1'b1;
      req_tdata  <= REQ_DATA_W'({carb, prot, energy, moist, id});
      req_tuser  <= cat;
      req_tlast  <= last;
      do @(posedge clock); while (!req_tready);
      pace_sender();
   endtask

   function automatic int unsigned pick_value(input int unsigned max_v);
      case ($urandom_range(0, 7))
         0:       return 0;
         1:       return max_v;
         2:       return $urandom_range(1, 3);
         3:       return max_v / 2;
         default: return $urandom_range(0, max_v);
      endcase
   endfunction

   task automatic send_random(input logic [CAT_W-1:0] match_cat, input int stray_pct,
                              input logic last);
      logic [CAT_W-1:0] cat;
      cat = ($urandom_range(0, 99) < stray_pct) ? CAT_W'($urandom_range(0, 10)) : match_cat;
      send_record(ID_W'($urandom_range(0, 65535)), cat, VAL_W'(pick_value(MOIST_MAX)),
                  ENERGY_W'(pick_value(ENERGY_MAX)), VAL_W'(pick_value(MOIST_MAX)),
                  VAL_W'(pick_value(MOIST_MAX)), last);
   endtask

   task automatic write_csr(input logic [CSR_ADDR_W-1:0] addr,
                            input logic [CSR_DATA_W-1:0] data);
      csr_wen   <= 1'b1;
      csr_addr  <= addr;
      csr_wdata <= data;
      @(posedge clock);
      csr_wen   <= 1'b0;
      @(posedge clock);
   endtask

   task automatic configure(input int cat, input int crit, input int top);
      write_csr(CSR_CATEGORY, CSR_DATA_W'(cat));
      write_csr(CSR_CRITERION, CSR_DATA_W'(crit));
      write_csr(CSR_TOP_COUNT, CSR_DATA_W'(top));
   endtask

   task automatic drain();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   initial begin : stimulus
      int random_sent;
      int set_size;
      int match_cat;
      int top;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      repeat (2) @(posedge clock);

      // Register defaults: category 0, energy key, all entries; ties keep arrival order.
      send_record(16'h0000, 4'd0, 14'd0, 17'd0, 14'd0, 14'd0, 1'b0);
      send_record(16'hFFFF, 4'd0, 14'd10000, 17'd100000, 14'd10000, 14'd10000, 1'b0);
      send_record(16'h0001, 4'd1, 14'd5000, 17'd50000, 14'd100, 14'd100, 1'b0);
      send_record(16'h0002, 4'd0, 14'd1, 17'd100000, 14'd2, 14'd3, 1'b0);
      send_record(16'h0003, CAT_OTHER, 14'd9999, 17'd99999, 14'd1, 14'd1, 1'b0);
      send_record(16'h0004, 4'd0, 14'd8192, 17'd77, 14'd4096, 14'd2048, 1'b1);
      drain();

      configure(CAT_OTHER, CRIT_ENERGY, 64);
      send_record(16'h0005, CAT_OTHER, 14'd10, 17'd10, 14'd10, 14'd10, 1'b1);
      drain();

      configure(15, CRIT_ENERGY, 64);
      send_record(16'h0006, CAT_OTHER, 14'd10, 17'd10, 14'd10, 14'd10, 1'b1);
      drain();

      configure(3, CRIT_EN_PROT, 0);
      send_record(16'h0010, 4'd3, 14'd1, 17'd100000, 14'd0, 14'd5, 1'b0);
      send_record(16'h0011, 4'd3, 14'd2, 17'd100000, 14'd1, 14'd5, 1'b0);
      send_record(16'h0012, 4'd3, 14'd3, 17'd12345, 14'd7, 14'd5, 1'b1);
      drain();

      configure(9, CRIT_EN_CARB, 2);
      send_record(16'h0020, 4'd9, 14'd1, 17'd500, 14'd1, 14'd0, 1'b0);
      send_record(16'h0021, 4'd9, 14'd1, 17'd10, 14'd1, 14'd3, 1'b0);
      send_record(16'h0022, 4'd9, 14'd1, 17'd100000, 14'd1, 14'd10000, 1'b1);
      drain();

      configure(5, CRIT_UNKNOWN, 64);
      send_record(16'h0030, 4'd5, 14'd100, 17'd3, 14'd40, 14'd9, 1'b0);
      send_record(16'h0031, 4'd5, 14'd10000, 17'd100000, 14'd10000, 14'd10000, 1'b0);
      send_record(16'h0032, 4'd5, 14'd7, 17'd1, 14'd2, 14'd3, 1'b1);
      drain();

      configure(2, CRIT_MOISTURE, 1);
      send_record(16'h0040, 4'd2, 14'd10000, 17'd1, 14'd1, 14'd1, 1'b0);
      send_record(16'h0041, 4'd2, 14'd0, 17'd2, 14'd2, 14'd2, 1'b1);
      drain();

      // Overfill the store, then keep offering the next set while the receiver holds off.
      match_cat = $urandom_range(0, 9);
      configure(match_cat, $urandom_range(CRIT_MOISTURE, CRIT_EN_CARB), 64);
      hold_armed = 1'b1;
      for (int i = 0; i < 70; i++) send_random(CAT_W'(match_cat), 5, i == 69);
      for (int i = 0; i < 6; i++) send_random(CAT_W'(match_cat), 25, i == 5);
      random_sent = 76;
      drain();

      while (random_sent < RANDOM_ITEMS) begin
         match_cat = ($urandom_range(0, 9) == 0) ? CAT_OTHER : $urandom_range(0, 9);
         case ($urandom_range(0, 3))
            0:       top = 1;
            1:       top = 64;
            2:       top = $urandom_range(1, 4);
            default: top = $urandom_range(1, 64);
         endcase
         configure(match_cat, $urandom_range(CRIT_MOISTURE, CRIT_EN_CARB), top);
         set_size = ($urandom_range(0, 3) == 0) ? $urandom_range(9, 16) : $urandom_range(1, 6);
         for (int i = 0; i < set_size; i++)
            send_random(CAT_W'(match_cat), 25, i == set_size - 1);
         random_sent += set_size;
         drain();
      end

      if (errors == 0 && pending == 0)
         $display("** top_n_by_criterion_sorter: PASSED **");
      else
         $display("** top_n_by_criterion_sorter: FAILED **");
      $finish;
   end

endmodule

// ----- sim.f -----
hdl/tnbc_pkg.sv
hdl/tnbc_div.sv
hdl/tnbc_cell.sv
hdl/top_n_by_criterion_sorter.sv
hdl/tnbc_checker.sv
sim/top_n_rank_checker.sv
sim/top_n_by_criterion_sorter_test.sv
